// ----- design/rls_pkg.sv -----
// Package for the run-length stack: field widths, operation and status codes,
// the stored run entry, the result record and the sequencer state type.
// No dependencies.
package rls_pkg;

  localparam int TYPE_W  = 8;
  localparam int COUNT_W = 24;
  localparam int TOTAL_W = 28;
  localparam int AMT_W   = 16;
  localparam int MAX_OUT = 16;
  localparam int LREM_W  = $clog2(MAX_OUT + 1);

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_LIST = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [TYPE_W-1:0]  typ;
    logic [COUNT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  typ;
    logic [COUNT_W-1:0] cnt;
    logic [TOTAL_W-1:0] total;
    logic               empty;
    logic [1:0]         status;
    logic               last;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_POP  = 5'b00100,
    ST_TOP  = 5'b01000,
    ST_LIST = 5'b10000
  } state_t;

endpackage

// ----- design/rls_run_mem.sv -----
// Run storage: one synchronous memory of (type, count) entries, one write
// port and one read port with registered read data. Depends on rls_pkg.
module rls_run_mem #(
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  rls_pkg::entry_t      wdata,
  input  logic [ADDR_W-1:0]    raddr,
  output rls_pkg::entry_t      rdata
);
  import rls_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/rls_ctrl.sv -----
// Sequencer of the run-length stack: takes one item at a time, reads the
// top run, modifies and writes it back, walks runs for pops and listing.
// Depends on rls_pkg and rls_run_mem.
module rls_ctrl #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic [rls_pkg::TYPE_W-1:0]    item_type,
  input  logic [rls_pkg::AMT_W-1:0]     amount,
  input  logic                          out_free,
  output logic                          emit,
  output rls_pkg::result_t              res
);
  import rls_pkg::*;

  localparam int PTR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  state_t              state, state_next;
  logic [CNT_W-1:0]    used, used_next;
  logic [TOTAL_W-1:0]  total, total_next;
  func_t               op_func;
  logic [TYPE_W-1:0]   op_type;
  logic [AMT_W-1:0]    op_amt;
  logic [AMT_W-1:0]    left, left_next;
  logic [PTR_W-1:0]    lidx, lidx_next;
  logic [LREM_W-1:0]   lrem, lrem_next;

  logic                we;
  logic [PTR_W-1:0]    waddr;
  entry_t              wdata;
  logic [PTR_W-1:0]    raddr;
  entry_t              rd_q;

  rls_run_mem #(.DEPTH(STACK_DEPTH), .ADDR_W(PTR_W)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_q)
  );

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    logic [CNT_W-1:0]   used_m1;
    logic [CNT_W-1:0]   used_m2;
    logic [CNT_W-1:0]   used_next_m1;
    logic [TOTAL_W:0]   sum_total;
    logic [COUNT_W:0]   sum_cnt;
    logic [LREM_W-1:0]  n_list;
    logic               rd_list;
    result_t            top_res;

    used_m1   = used - CNT_W'(1);
    used_m2   = used - CNT_W'(2);
    sum_total = {1'b0, total} + (TOTAL_W + 1)'(op_amt);
    sum_cnt   = {1'b0, rd_q.cnt} + (COUNT_W + 1)'(op_amt);
    if (32'(used) > MAX_OUT) begin
      n_list = LREM_W'(MAX_OUT);
    end else begin
      n_list = LREM_W'(used);
    end

    top_res = '0;
    if (used != '0) begin
      top_res.typ = rd_q.typ;
      top_res.cnt = rd_q.cnt;
    end
    top_res.last = 1'b1;

    state_next = state;
    used_next  = used;
    total_next = total;
    left_next  = left;
    lidx_next  = lidx;
    lrem_next  = lrem;
    we         = 1'b0;
    waddr      = used_m1[PTR_W-1:0];
    wdata      = rd_q;
    emit       = 1'b0;
    res        = top_res;
    rd_list    = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
          unique case (op_func)
            FUNC_PUSH: begin
              emit = 1'b1;
              priority if (op_amt == '0) begin
                res.status = STATUS_OK;
              end else if (sum_total[TOTAL_W]) begin
                res.status = STATUS_OVERFLOW;
              end else if (used != '0 && rd_q.typ == op_type) begin
                if (sum_cnt[COUNT_W]) begin
                  res.status = STATUS_OVERFLOW;
                end else begin
                  // merge into the top run
                  we         = 1'b1;
                  wdata.typ  = op_type;
                  wdata.cnt  = sum_cnt[COUNT_W-1:0];
                  total_next = sum_total[TOTAL_W-1:0];
                  res.typ    = op_type;
                  res.cnt    = sum_cnt[COUNT_W-1:0];
                end
              end else if (used == CNT_W'(STACK_DEPTH)) begin
                res.status = STATUS_OVERFLOW;
              end else begin
                // open a new run on top
                we         = 1'b1;
                waddr      = used[PTR_W-1:0];
                wdata.typ  = op_type;
                wdata.cnt  = COUNT_W'(op_amt);
                used_next  = used + CNT_W'(1);
                total_next = sum_total[TOTAL_W-1:0];
                res.typ    = op_type;
                res.cnt    = COUNT_W'(op_amt);
              end
            end

            FUNC_POP: begin
              priority if (op_amt == '0) begin
                emit = 1'b1;
              end else if (TOTAL_W'(op_amt) > total) begin
                emit       = 1'b1;
                used_next  = '0;
                total_next = '0;
                res.typ    = '0;
                res.cnt    = '0;
                res.status = STATUS_UNDERFLOW;
              end else begin
                total_next = total - TOTAL_W'(op_amt);
                left_next  = op_amt;
                state_next = ST_POP;
              end
            end

            FUNC_LIST: begin
              emit = 1'b1;
              if (used != '0) begin
                res.last = (n_list == LREM_W'(1));
                if (n_list != LREM_W'(1)) begin
                  lrem_next  = n_list - LREM_W'(1);
                  lidx_next  = used_m2[PTR_W-1:0];
                  rd_list    = 1'b1;
                  state_next = ST_LIST;
                end
              end
            end

            FUNC_NOP: begin
              emit = 1'b1;
            end

            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_POP: begin
        if (rd_q.cnt > COUNT_W'(left)) begin
          // the pop ends inside this run
          if (out_free) begin
            we         = 1'b1;
            wdata.cnt  = rd_q.cnt - COUNT_W'(left);
            emit       = 1'b1;
            res.typ    = rd_q.typ;
            res.cnt    = rd_q.cnt - COUNT_W'(left);
            state_next = ST_IDLE;
          end
        end else begin
          // drop the whole run, then look at the one below
          left_next = left - rd_q.cnt[AMT_W-1:0];
          used_next = used_m1;
          if (left_next == '0) begin
            state_next = ST_TOP;
          end
        end
      end

      ST_TOP: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_LIST: begin
        rd_list = 1'b1;
        if (out_free) begin
          emit      = 1'b1;
          res.typ   = rd_q.typ;
          res.cnt   = rd_q.cnt;
          res.last  = (lrem == LREM_W'(1));
          lrem_next = lrem - LREM_W'(1);
          if (lrem == LREM_W'(1)) begin
            rd_list    = 1'b0;
            state_next = ST_IDLE;
          end else begin
            lidx_next = lidx - PTR_W'(1);
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res.total = total_next;
    res.empty = (used_next == '0);

    // read next cycle's top run, or the next run of a listing
    used_next_m1 = used_next - CNT_W'(1);
    if (rd_list) begin
      raddr = lidx_next;
    end else begin
      raddr = used_next_m1[PTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_func <= func_t'(func);
      op_type <= item_type;
      op_amt  <= amount;
    end
    left <= left_next;
    lidx <= lidx_next;
    lrem <= lrem_next;
  end

endmodule

// ----- design/run_length_stack.sv -----
// Run-length stack top level: sequencer with run memory plus the output
// register that decouples the result channel. Depends on rls_pkg, rls_ctrl.
//
// A stack of (type, count) runs kept in one synchronous memory of
// STACK_DEPTH entries; entry count and item total live in registers. One
// item is taken at a time (in_stall is high while an item is in work). With
// no result stall, in a push or no-op the accept cycle reads the top run,
// and the next cycle modifies and writes it back and produces the result.
// A pop that is zero or exceeds the contents finishes the same way;
// otherwise it then drops each run it empties in turn and ends either
// inside a run or, exactly on a run boundary, with a read of the new top.
// A list gives its first result as a push does, then the runs below it in
// turn (at most 16 results). Each run visited costs one read on the memory's
// single read port, which has registered read data. The result sits in an
// output register, so the next item may be accepted while a result still
// waits on out_stall; a busy output register holds the sequencer. The run
// memory needs no clearing after reset: only runs below the entry count
// are ever used.
module run_length_stack #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic [rls_pkg::TYPE_W-1:0]    item_type,
  input  logic [rls_pkg::AMT_W-1:0]     amount,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rls_pkg::TYPE_W-1:0]    entry_type,
  output logic [rls_pkg::COUNT_W-1:0]   entry_count,
  output logic [rls_pkg::TOTAL_W-1:0]   total_items,
  output logic                          stack_empty,
  output logic [1:0]                    status,
  output logic                          last
);
  import rls_pkg::*;

  logic    out_free;
  logic    emit;
  result_t res;

  // the output register can take a new item when empty or being drained
  assign out_free = !out_valid || !out_stall;

  rls_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .item_type (item_type),
    .amount    (amount),
    .out_free  (out_free),
    .emit      (emit),
    .res       (res)
  );

  // hold the valid flag until the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  // load the payload only when a new item enters; hold it while stalled
  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      entry_type  <= res.typ;
      entry_count <= res.cnt;
      total_items <= res.total;
      stack_empty <= res.empty;
      status      <= res.status;
      last        <= res.last;
    end
  end

endmodule

// ----- dv/rls_checker.sv -----
// Checker for the run-length stack: watches both channels, predicts each result
// item from its own copy of the runs, and compares results field by field.
// Depends on rls_pkg.
module rls_checker #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  func,
  input  logic [rls_pkg::TYPE_W-1:0]  item_type,
  input  logic [rls_pkg::AMT_W-1:0]   amount,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [rls_pkg::TYPE_W-1:0]  entry_type,
  input  logic [rls_pkg::COUNT_W-1:0] entry_count,
  input  logic [rls_pkg::TOTAL_W-1:0] total_items,
  input  logic                        stack_empty,
  input  logic [1:0]                  status,
  input  logic                        last,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rls_pkg::*;

  localparam int COUNT_LIMIT = (1 << COUNT_W) - 1;
  localparam int TOTAL_LIMIT = (1 << TOTAL_W) - 1;

  // Shadow copy of the stored runs; only entries below run_depth are read.
  logic [TYPE_W-1:0]  run_type  [STACK_DEPTH];
  logic [COUNT_W-1:0] run_count [STACK_DEPTH];
  int                 run_depth;
  int                 stored_total;
  result_t            expected_results[$];

  task automatic report(input string what, input logic [31:0] want_v,
                        input logic [31:0] got_v);
    $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
             want_v, got_v);
    fail_count++;
  endtask

  function automatic result_t make_result(input logic [TYPE_W-1:0] t,
                                          input logic [COUNT_W-1:0] c,
                                          input logic [1:0] st, input logic lst);
    result_t r;
    r.typ    = t;
    r.cnt    = c;
    r.total  = stored_total[TOTAL_W-1:0];
    r.empty  = (run_depth == 0);
    r.status = st;
    r.last   = lst;
    return r;
  endfunction

  function automatic result_t top_result(input logic [1:0] st);
    if (run_depth == 0) return make_result('0, '0, st, 1'b1);
    return make_result(run_type[run_depth-1], run_count[run_depth-1], st, 1'b1);
  endfunction

  task automatic predict_item(input func_t f, input logic [TYPE_W-1:0] t,
                              input logic [AMT_W-1:0] a);
    logic [1:0] st;
    int left;
    int n;
    int idx;
    st = STATUS_OK;
    case (f)
      FUNC_PUSH: begin
        if (a != 0) begin
          if (stored_total + int'(a) > TOTAL_LIMIT) begin
            st = STATUS_OVERFLOW;
          end else if (run_depth > 0 && run_type[run_depth-1] == t) begin
            if (int'(run_count[run_depth-1]) + int'(a) > COUNT_LIMIT) begin
              st = STATUS_OVERFLOW;
            end else begin
              run_count[run_depth-1] = run_count[run_depth-1] + a;
              stored_total += int'(a);
            end
          end else if (run_depth >= STACK_DEPTH) begin
            st = STATUS_OVERFLOW;
          end else begin
            run_type[run_depth]  = t;
            run_count[run_depth] = COUNT_W'(a);
            run_depth++;
            stored_total += int'(a);
          end
        end
        expected_results.push_back(top_result(st));
      end
      FUNC_POP: begin
        if (a != 0) begin
          if (int'(a) > stored_total) begin
            run_depth    = 0;
            stored_total = 0;
            st           = STATUS_UNDERFLOW;
          end else begin
            left = int'(a);
            stored_total -= left;
            // take from the top run, dropping each run that runs dry
            while (left > 0 && run_depth > 0) begin
              if (int'(run_count[run_depth-1]) > left) begin
                run_count[run_depth-1] = run_count[run_depth-1] - COUNT_W'(left);
                left = 0;
              end else begin
                left -= int'(run_count[run_depth-1]);
                run_count[run_depth-1] = '0;
                run_depth--;
              end
            end
          end
        end
        expected_results.push_back(top_result(st));
      end
      FUNC_LIST: begin
        if (run_depth == 0) begin
          expected_results.push_back(make_result('0, '0, STATUS_OK, 1'b1));
        end else begin
          n = (run_depth > MAX_OUT) ? MAX_OUT : run_depth;
          for (int k = 0; k < n; k++) begin
            idx = run_depth - 1 - k;
            expected_results.push_back(make_result(run_type[idx], run_count[idx],
                                                   STATUS_OK, k == n - 1));
          end
        end
      end
      default: expected_results.push_back(top_result(STATUS_OK));
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      run_depth    = 0;
      stored_total = 0;
      expected_results.delete();
    end else begin
      // results first: the item accepted at this edge cannot have a result yet
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("result with nothing pending, entry_count", '0, 32'(entry_count));
        end else begin
          want = expected_results.pop_front();
          if (entry_type !== want.typ)    report("entry_type", want.typ, entry_type);
          if (entry_count !== want.cnt)   report("entry_count", want.cnt, entry_count);
          if (total_items !== want.total) report("total_items", want.total, total_items);
          if (stack_empty !== want.empty) report("stack_empty", want.empty, stack_empty);
          if (status !== want.status)     report("status", want.status, status);
          if (last !== want.last)         report("last", want.last, last);
        end
      end
      if (in_valid && !in_stall) predict_item(func_t'(func), item_type, amount);
    end
    pending = expected_results.size();
  end

endmodule

// ----- dv/tb.sv -----
// Top of the run-length stack testbench: clock, reset, item stimulus with
// bursty sending and patterned result stalls, watchdog and verdict.
// Depends on rls_pkg, run_length_stack and rls_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rls_pkg::*;

  localparam int STACK_DEPTH    = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_ITEMS   = 75;

  // result stall patterns
  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_HEAVY  = 2;
  localparam int STALL_BLOCKS = 3;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [1:0]         func      = FUNC_PUSH;
  logic [TYPE_W-1:0]  item_type = '0;
  logic [AMT_W-1:0]   amount    = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [TYPE_W-1:0]  entry_type;
  logic [COUNT_W-1:0] entry_count;
  logic [TOTAL_W-1:0] total_items;
  logic               stack_empty;
  logic [1:0]         status;
  logic               last;
  int                 fail_count;
  int                 pending;

  run_length_stack #(.STACK_DEPTH(STACK_DEPTH)) u_dut (
    .clk, .rst,
    .in_valid, .in_stall, .func, .item_type, .amount,
    .out_valid, .out_stall, .entry_type, .entry_count, .total_items,
    .stack_empty, .status, .last
  );

  rls_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
    .clk, .rst,
    .in_valid, .in_stall, .func, .item_type, .amount,
    .out_valid, .out_stall, .entry_type, .entry_count, .total_items,
    .stack_empty, .status, .last,
    .fail_count, .pending
  );

  always #5 clk = ~clk;

  // Result side: pick a stall pattern, hold it for a random stretch, then
  // switch. Patterns range from never stalling to stalling most cycles.
  int stall_mode = STALL_NONE;
  int mode_left  = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_BLOCKS);
      mode_left  = $urandom_range(16, 64);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((mode_left % 8) < 5);
    endcase
  end

  // Watchdog: any cycle moving an item on either channel restarts the count.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sender: items go out in bursts of random length; between bursts valid
  // drops for a random gap, and some bursts run straight into the next.
  int burst_left = 0;

  // Call at a falling edge; returns at a falling edge with the item taken.
  task automatic send_item(input logic [1:0] f, input logic [TYPE_W-1:0] t,
                           input logic [AMT_W-1:0] a);
    int gap;
    in_valid  <= 1'b1;
    func      <= f;
    item_type <= t;
    amount    <= a;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      // hold valid high across a zero gap; never drop and raise in one step
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Random item: push-heavy so runs build up; a small type pool makes merges
  // common, and full-width amounts make pops past the contents happen.
  task automatic send_random();
    int                pick;
    logic [TYPE_W-1:0] t;
    logic [AMT_W-1:0]  a;
    pick = $urandom_range(0, 99);
    t = ($urandom_range(0, 1) == 0) ? TYPE_W'($urandom_range(0, 3))
                                    : TYPE_W'($urandom_range(0, 255));
    a = ($urandom_range(0, 3) == 0) ? AMT_W'($urandom) : AMT_W'($urandom_range(0, 400));
    if (pick < 45)      send_item(FUNC_PUSH, t, a);
    else if (pick < 75) send_item(FUNC_POP, t, a);
    else if (pick < 90) send_item(FUNC_LIST, t, a);
    else                send_item(FUNC_NOP, t, a);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: operations on the empty stack, zero amounts, extreme types
    // and amounts, a merge, pops inside a run, on a run boundary and across
    // runs, and a pop past the contents that leaves the stack empty.
    send_item(FUNC_LIST, 8'h00, 16'h0000);
    send_item(FUNC_NOP,  8'hFF, 16'hFFFF);
    send_item(FUNC_POP,  8'h00, 16'd5);
    send_item(FUNC_POP,  8'h00, 16'd0);
    send_item(FUNC_PUSH, 8'h09, 16'd0);
    send_item(FUNC_PUSH, 8'h00, 16'd1);
    send_item(FUNC_PUSH, 8'h00, 16'hFFFF);
    send_item(FUNC_PUSH, 8'hFF, 16'hFFFF);
    send_item(FUNC_PUSH, 8'hAA, 16'h5555);
    send_item(FUNC_PUSH, 8'h55, 16'hAAAA);
    send_item(FUNC_PUSH, 8'h55, 16'd0);
    send_item(FUNC_POP,  8'hFF, 16'd0);
    send_item(FUNC_NOP,  8'h00, 16'h0000);
    send_item(FUNC_LIST, 8'h00, 16'h0000);
    send_item(FUNC_POP,  8'h00, 16'd1);
    send_item(FUNC_POP,  8'h00, 16'hAAA9);
    send_item(FUNC_POP,  8'h00, 16'h5555 + 16'd100);
    send_item(FUNC_LIST, 8'h00, 16'h0000);
    send_item(FUNC_POP,  8'h00, 16'hFFFF);
    send_item(FUNC_POP,  8'h00, 16'hFFFF);
    send_item(FUNC_NOP,  TYPE_W'($urandom), AMT_W'($urandom));
    send_item(FUNC_LIST, 8'h00, 16'h0000);

    // Fill: one run per type until the stack is full (counts 1 to 16).
    for (int r = 0; r < STACK_DEPTH; r++) begin
      send_item(FUNC_PUSH, TYPE_W'(r * 17), AMT_W'(r + 1));
    end
    // new run on a full stack is refused, a merge into the top still fits,
    // then a listing of every run
    send_item(FUNC_PUSH, 8'd200, 16'd1);
    send_item(FUNC_PUSH, TYPE_W'((STACK_DEPTH - 1) * 17), 16'd1000);
    send_item(FUNC_LIST, 8'h00, 16'h0000);
    // drop the top two runs and end inside the third, open a new run, then
    // pop exactly the remaining total so every run goes on a boundary
    send_item(FUNC_POP,  8'h00, 16'd1036);
    send_item(FUNC_PUSH, 8'd7,  16'd50);
    send_item(FUNC_POP,  8'h00, 16'd150);
    send_item(FUNC_LIST, 8'h00, 16'h0000);

    repeat (RANDOM_ITEMS) send_random();

    // Drop valid, let every expected result drain, then watch a little longer
    // for results nobody asked for.
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
